### hw/rtl/pba_pkg.sv
// Shared types and constants for the page bitmap allocator.
`default_nettype none

package pba_pkg;

  localparam int PAGE_W   = 17;
  localparam int WORD_W   = 11;
  localparam int CNT_W    = 17;
  localparam int BITS     = 64;
  localparam int LOG_BITS = 6;
  localparam int RUN_W    = 7;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE   = 2'd0;
  localparam logic [1:0] STATUS_NO_RUN = 2'd1;
  localparam logic [1:0] STATUS_REJECT = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [15:0] first_page;
    logic [16:0] page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] run_start;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RANGE,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic scan_en;
    logic range_en;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic early_done;
    logic is_free;
    logic scan_hit;
    logic scan_miss;
    logic range_last;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/page_bitmap_allocator.sv
// Top level of the first-fit page bitmap allocator.
//
// One bit per page, 1 = allocated, held in a RAM of MAX_WORDS 64-bit words.
// After reset the block runs a fill pass that sets every word to all ones;
// busy stays high through it. A word is accepted when start is high and busy
// is low; exactly one result follows, shown for one cycle with done high, and
// the receiver cannot hold it off. An allocate reads one bitmap word per cycle
// from page 0 until it finds the run, then rewrites one word per cycle over
// the run. A free rewrites one word per cycle over its range. Rejected or
// empty requests go straight to the result. The single read port of the
// bitmap RAM sets these rates. words_in_use may be written only while busy
// is low.
`default_nettype none

module page_bitmap_allocator import pba_pkg::*; #(
  parameter int MAX_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  output logic              done,
  output rsp_t              rsp
);

  cmd_t cmd;
  sts_t sts;

  pba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pba_datapath #(
    .MAX_WORDS (MAX_WORDS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req         (req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rsp         (rsp)
  );

endmodule

`default_nettype wire

### hw/rtl/pba_ram.sv
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module pba_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hw/rtl/pba_ctrl.sv
// Controller state machine for the page bitmap allocator.
`default_nettype none

module pba_ctrl import pba_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (sts.early_done) begin
            state_next = S_REPORT;
          end else if (sts.is_free) begin
            state_next = S_RANGE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_hit) begin
          state_next = S_RANGE;
        end else if (sts.scan_miss) begin
          state_next = S_REPORT;
        end
      end
      S_RANGE: begin
        if (sts.range_last) state_next = S_REPORT;
      end
      S_REPORT: state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_CLEAR: cmd.clear_en = 1'b1;
      S_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      S_SCAN:   cmd.scan_en = 1'b1;
      S_RANGE:  cmd.range_en = 1'b1;
      S_REPORT: done = 1'b1;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/pba_datapath.sv
// Datapath: bitmap RAM, word scan, run tracking and range marking.
`default_nettype none

module pba_datapath import pba_pkg::*; #(
  parameter int MAX_WORDS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  req_t              req,
  input  logic              cfg_wr_en,
  input  logic [WORD_W-1:0] cfg_wr_data,
  output rsp_t              rsp
);

  localparam int ADDR_W = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  logic [WORD_W-1:0] words_in_use;
  logic [ADDR_W-1:0] clr_idx;
  logic              op;
  logic [CNT_W-1:0]  count;
  logic [WORD_W-1:0] ridx;
  logic [WORD_W-1:0] eidx;
  logic              dvalid;
  logic [PAGE_W-1:0] run_len;
  logic [PAGE_W-1:0] run_base;
  logic [PAGE_W-1:0] rng_first;
  logic [PAGE_W-1:0] rng_last;
  rsp_t              rsp_reg;

  logic [WORD_W-1:0] active;
  logic [PAGE_W-1:0] pages;
  logic [PAGE_W:0]   free_sum;
  logic              free_bad;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BITS-1:0]   ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BITS-1:0]   rdata;

  logic [BITS-1:0]     free_bits;
  logic [BITS-1:0]     pmask;
  logic [BITS-1:0]     rmask;
  logic [RUN_W-1:0]    lead_free;
  logic [RUN_W-1:0]    top_free;
  logic [LOG_BITS-1:0] int_pos;
  logic                int_hit;
  logic [CNT_W-1:0]    need;
  logic                carry_hit;
  logic                hit;
  logic                all_free;
  logic [PAGE_W-1:0]   word_base;
  logic [PAGE_W-1:0]   cand;
  logic [PAGE_W-1:0]   run_len_next;
  logic [PAGE_W-1:0]   run_base_next;

  logic [LOG_BITS-1:0] lo_bit;
  logic [LOG_BITS-1:0] hi_bit;
  logic [BITS-1:0]     wmask;

  assign active   = (32'(words_in_use) > 32'(MAX_WORDS)) ? WORD_W'(MAX_WORDS) : words_in_use;
  assign pages    = {active, LOG_BITS'(0)};
  assign free_sum = {2'b00, req.first_page} + {1'b0, req.page_count};
  assign free_bad = (req.first_page == '0) || (free_sum > {1'b0, pages});

  assign sts.clear_last = (clr_idx == ADDR_W'(MAX_WORDS - 1));
  assign sts.is_free    = (req.operation == OP_FREE);
  assign sts.early_done = (req.operation == OP_ALLOC)
                        ? ((req.page_count == '0) || (active == '0))
                        : (free_bad || (req.page_count == '0));
  assign sts.scan_hit   = dvalid && hit;
  assign sts.scan_miss  = dvalid && !hit && (eidx == active - WORD_W'(1));
  assign sts.range_last = dvalid && (eidx == rng_last[PAGE_W-1:LOG_BITS]);

  // word evaluation for the first-fit scan
  always_comb begin
    free_bits = ~rdata;
    all_free  = &free_bits;
    word_base = {eidx, LOG_BITS'(0)};

    lead_free = RUN_W'(BITS);
    for (int i = BITS - 1; i >= 0; i--) begin
      if (!free_bits[i]) lead_free = RUN_W'(i);
    end
    top_free = RUN_W'(BITS);
    for (int i = 0; i < BITS; i++) begin
      if (!free_bits[i]) top_free = RUN_W'(BITS - 1 - i);
    end

    pmask = free_bits;
    rmask = '1;
    for (int i = 0; i < RUN_W; i++) begin
      if (count[i]) rmask = (rmask << (1 << i)) & pmask;
      pmask = pmask & (pmask << (1 << i));
    end
    int_hit = (count <= CNT_W'(BITS)) && (|rmask);
    int_pos = '0;
    for (int i = BITS - 1; i >= 0; i--) begin
      if (rmask[i]) int_pos = LOG_BITS'(i);
    end

    need      = count - run_len;
    carry_hit = (need <= CNT_W'(lead_free));
    hit       = carry_hit || int_hit;

    if (carry_hit) begin
      cand = (run_len == '0) ? word_base : run_base;
    end else begin
      cand = word_base + PAGE_W'(int_pos) + PAGE_W'(1) - count;
    end

    if (all_free) begin
      run_len_next  = run_len + PAGE_W'(BITS);
      run_base_next = (run_len == '0) ? word_base : run_base;
    end else begin
      run_len_next  = PAGE_W'(top_free);
      run_base_next = word_base + PAGE_W'(BITS) - PAGE_W'(top_free);
    end
  end

  always_comb begin
    lo_bit = (eidx == rng_first[PAGE_W-1:LOG_BITS]) ? rng_first[LOG_BITS-1:0] : '0;
    hi_bit = (eidx == rng_last[PAGE_W-1:LOG_BITS]) ? rng_last[LOG_BITS-1:0] : '1;
    wmask  = ({BITS{1'b1}} << lo_bit) & ({BITS{1'b1}} >> (~hi_bit));
  end

  always_comb begin
    ram_we    = cmd.clear_en || (cmd.range_en && dvalid);
    ram_waddr = cmd.clear_en ? clr_idx : ADDR_W'(eidx);
    if (cmd.clear_en) begin
      ram_wdata = '1;
    end else if (op == OP_ALLOC) begin
      ram_wdata = rdata | wmask;
    end else begin
      ram_wdata = rdata & ~wmask;
    end
    ram_raddr = ADDR_W'(ridx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= WORD_W'(1024);
    end else if (cfg_wr_en) begin
      words_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_en) begin
      clr_idx <= clr_idx + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= 1'b0;
    end else if (cmd.accept) begin
      dvalid <= 1'b0;
    end else if (cmd.scan_en) begin
      dvalid <= !(dvalid && hit);
    end else if (cmd.range_en) begin
      dvalid <= (ridx <= rng_last[PAGE_W-1:LOG_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op        <= req.operation;
      count     <= req.page_count;
      ridx      <= (req.operation == OP_ALLOC) ? '0
                 : WORD_W'(req.first_page >> LOG_BITS);
      run_len   <= '0;
      run_base  <= '0;
      rng_first <= PAGE_W'(req.first_page);
      rng_last  <= PAGE_W'(free_sum - 18'd1);
      rsp_reg.run_start <= '0;
      if (req.operation == OP_ALLOC) begin
        rsp_reg.status <= STATUS_NO_RUN;
      end else if (free_bad) begin
        rsp_reg.status <= STATUS_REJECT;
      end else begin
        rsp_reg.status <= STATUS_DONE;
      end
    end else if (cmd.scan_en) begin
      if (dvalid && hit) begin
        ridx              <= cand[PAGE_W-1:LOG_BITS];
        rng_first         <= cand;
        rng_last          <= cand + count - PAGE_W'(1);
        rsp_reg.status    <= STATUS_DONE;
        rsp_reg.run_start <= cand[15:0];
      end else begin
        ridx <= ridx + WORD_W'(1);
        eidx <= ridx;
        if (dvalid) begin
          run_len  <= run_len_next;
          run_base <= run_base_next;
        end
      end
    end else if (cmd.range_en) begin
      ridx <= ridx + WORD_W'(1);
      eidx <= ridx;
    end
  end

  assign rsp = rsp_reg;

  pba_ram #(
    .WIDTH (BITS),
    .DEPTH (MAX_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

### hw/rtl/pba_checker.sv
// Port-level assertions for the page bitmap allocator, bound to the top level.
`default_nettype none

module pba_checker import pba_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input rsp_t rsp
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("block not idle after result");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == STATUS_DONE || rsp.status == STATUS_NO_RUN ||
              rsp.status == STATUS_REJECT))
    else $error("undefined status code");

  a_fail_start: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STATUS_DONE) |-> (rsp.run_start == '0))
    else $error("failed request returned a page");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
